### hdl/ubxp_pkg.sv
// ----------------------------------------------------------------------------
// ubxp_pkg
// Shared types and constants for the UBX frame parser: phase and result
// codes, configuration register indexes, reset values and the event word
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
package ubxp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH  = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  RST_SYNC_FIRST  = 8'hB5;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'h62;
    localparam logic [15:0] RST_MAX_LENGTH  = 16'd1024;

    // Default depth of the queue between front and back end
    localparam int C_QUEUE_DEPTH = 4;

    // Receive phase
    typedef enum logic [3:0] {
        PH_HUNT1  = 4'd0,
        PH_HUNT2  = 4'd1,
        PH_CLASS  = 4'd2,
        PH_ID     = 4'd3,
        PH_LEN_LO = 4'd4,
        PH_LEN_HI = 4'd5,
        PH_BODY   = 4'd6,
        PH_SUM_A  = 4'd7,
        PH_SUM_B  = 4'd8
    } t_phase;

    // Result kind
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_SUM_ERR = 2'd2,
        KIND_LEN_ERR = 2'd3
    } t_kind;

    // One classified word from the front end
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [15:0] index;
        logic [7:0]  hdr_class;
        logic [7:0]  msg_id;
        logic [15:0] length;
    } t_event;

endpackage

### hdl/ubxp_front.sv
// ----------------------------------------------------------------------------
// ubxp_front
// Frame front end: hunts for sync, captures the header, runs the Fletcher
// checksum and turns each received word into zero or one event.
// ----------------------------------------------------------------------------
module ubxp_front
    import ubxp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_sync_first,
    input  logic [7:0]  i_sync_second,
    input  logic [15:0] i_max_length,
    output logic        o_event_valid,
    output t_event      o_event
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_got_sum_a, n_got_sum_a;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_length, n_length;
    logic [15:0] r_index, n_index;

    logic [7:0]  fold_a;
    logic [7:0]  fold_b;
    logic [15:0] len_full;
    logic [16:0] index_inc;

    // Fletcher step on the current word
    assign fold_a    = r_sum_a + i_rx_byte;
    assign fold_b    = r_sum_b + fold_a;
    assign len_full  = {i_rx_byte, r_length[7:0]};
    assign index_inc = {1'b0, r_index} + 17'd1;

    // Hold phase and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT1;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_got_sum_a <= '0;
            r_class     <= '0;
            r_id        <= '0;
            r_length    <= '0;
            r_index     <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_sum_a     <= n_sum_a;
            r_sum_b     <= n_sum_b;
            r_got_sum_a <= n_got_sum_a;
            r_class     <= n_class;
            r_id        <= n_id;
            r_length    <= n_length;
            r_index     <= n_index;
        end
    end

    // Classify the word and advance the phase
    always_comb begin
        n_phase       = r_phase;
        n_sum_a       = r_sum_a;
        n_sum_b       = r_sum_b;
        n_got_sum_a   = r_got_sum_a;
        n_class       = r_class;
        n_id          = r_id;
        n_length      = r_length;
        n_index       = r_index;
        o_event_valid = 1'b0;
        o_event.kind  = KIND_PAYLOAD;
        o_event.data  = '0;
        o_event.index = '0;
        case (r_phase)
            PH_HUNT2: begin
                // second sync wins over a repeated first sync
                if (i_rx_byte == i_sync_second) begin
                    n_phase = PH_CLASS;
                    n_sum_a = '0;
                    n_sum_b = '0;
                end else if (i_rx_byte != i_sync_first) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_CLASS: begin
                n_class = i_rx_byte;
                n_sum_a = fold_a;
                n_sum_b = fold_b;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_rx_byte;
                n_sum_a = fold_a;
                n_sum_b = fold_b;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length = {8'd0, i_rx_byte};
                n_sum_a  = fold_a;
                n_sum_b  = fold_b;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_length = len_full;
                n_sum_a  = fold_a;
                n_sum_b  = fold_b;
                if (len_full > i_max_length) begin
                    // report at once and restart the hunt
                    n_phase       = PH_HUNT1;
                    o_event_valid = 1'b1;
                    o_event.kind  = KIND_LEN_ERR;
                end else begin
                    n_index = '0;
                    n_phase = (len_full == 16'd0) ? PH_SUM_A : PH_BODY;
                end
            end
            PH_BODY: begin
                n_sum_a       = fold_a;
                n_sum_b       = fold_b;
                n_index       = index_inc[15:0];
                o_event_valid = 1'b1;
                o_event.kind  = KIND_PAYLOAD;
                o_event.data  = i_rx_byte;
                o_event.index = r_index;
                if (index_inc >= {1'b0, r_length}) begin
                    n_phase = PH_SUM_A;
                end
            end
            PH_SUM_A: begin
                n_got_sum_a = i_rx_byte;
                n_phase     = PH_SUM_B;
            end
            PH_SUM_B: begin
                n_phase       = PH_HUNT1;
                o_event_valid = 1'b1;
                if (r_got_sum_a == r_sum_a && i_rx_byte == r_sum_b) begin
                    o_event.kind = KIND_GOOD;
                end else begin
                    o_event.kind = KIND_SUM_ERR;
                end
            end
            default: begin
                n_phase = (i_rx_byte == i_sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
        o_event.hdr_class = n_class;
        o_event.msg_id    = n_id;
        o_event.length    = n_length;
    end

endmodule

### hdl/ubxp_queue.sv
// ----------------------------------------------------------------------------
// ubxp_queue
// Short first-in first-out queue of events between front and back end, so
// that each side stalls on its own.
// ----------------------------------------------------------------------------
module ubxp_queue
    import ubxp_pkg::*;
#(
    parameter int DEPTH = C_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_en,
    input  t_event i_wr_data,
    input  logic   i_rd_en,
    output t_event o_rd_data,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_fire;
    logic             rd_fire;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign wr_fire   = i_wr_en && !o_full;
    assign rd_fire   = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_fire) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_fire && !rd_fire) begin
                r_count <= r_count + 1'b1;
            end else if (rd_fire && !wr_fire) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/ubxp_back.sv
// ----------------------------------------------------------------------------
// ubxp_back
// Result back end: takes events in order, keeps the frame counters and holds
// the finished result word until it is popped.
// ----------------------------------------------------------------------------
module ubxp_back
    import ubxp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_event_valid,
    input  t_event      i_event,
    output logic        o_event_take,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_byte_index,
    output logic [7:0]  o_hdr_class,
    output logic [7:0]  o_msg_id,
    output logic [15:0] o_payload_length,
    output logic [31:0] o_frames_good,
    output logic [31:0] o_checksum_errors,
    output logic [31:0] o_length_errors
);

    logic        r_valid;
    t_event      r_result;
    logic [31:0] r_good;
    logic [31:0] r_sum_err;
    logic [31:0] r_len_err;
    logic        slot_free;

    // Load a new word when the output slot is empty or being drained
    assign slot_free    = !r_valid || i_pop;
    assign o_event_take = i_event_valid && slot_free;

    // Hold valid flag and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_good    <= '0;
            r_sum_err <= '0;
            r_len_err <= '0;
        end else begin
            if (slot_free) begin
                r_valid <= i_event_valid;
            end
            if (o_event_take) begin
                if (i_event.kind == KIND_GOOD) begin
                    r_good <= r_good + 32'd1;
                end
                if (i_event.kind == KIND_SUM_ERR) begin
                    r_sum_err <= r_sum_err + 32'd1;
                end
                if (i_event.kind == KIND_LEN_ERR) begin
                    r_len_err <= r_len_err + 32'd1;
                end
            end
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (o_event_take) begin
            r_result <= i_event;
        end
    end

    assign o_empty           = !r_valid;
    assign o_kind            = r_result.kind;
    assign o_payload_byte    = r_result.data;
    assign o_byte_index      = r_result.index;
    assign o_hdr_class       = r_result.hdr_class;
    assign o_msg_id          = r_result.msg_id;
    assign o_payload_length  = r_result.length;
    assign o_frames_good     = r_good;
    assign o_checksum_errors = r_sum_err;
    assign o_length_errors   = r_len_err;

endmodule

### hdl/ubx_frame_parser.sv
// ----------------------------------------------------------------------------
// ubx_frame_parser
// Byte-serial UBX frame receiver with 8-bit Fletcher checksum check, payload
// pass-through and wrapping good/checksum/length error counters.
//
// Path: each result passes the event queue and then the output register.
// Throughput: one word per cycle while full is low; the front end phase
// register closes the loop, and the event queue plus output register
// absorb output stalls.
// Reset: synchronous, active low; clears phase, checksum, counters, queue and
// output valid, and loads the default sync characters and length limit.
// ----------------------------------------------------------------------------
module ubx_frame_parser
    import ubxp_pkg::*;
#(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_byte_index,
    output logic [7:0]  o_hdr_class,
    output logic [7:0]  o_msg_id,
    output logic [15:0] o_payload_length,
    output logic [31:0] o_frames_good,
    output logic [31:0] o_checksum_errors,
    output logic [31:0] o_length_errors,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [7:0]  r_sync_first;
    logic [7:0]  r_sync_second;
    logic [15:0] r_max_length;

    logic        accept;
    logic        front_valid;
    t_event      front_event;
    t_event      queue_event;
    logic        queue_full;
    logic        queue_empty;
    logic        back_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= RST_SYNC_FIRST;
            r_sync_second <= RST_SYNC_SECOND;
            r_max_length  <= RST_MAX_LENGTH;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data[7:0];
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data[7:0];
                CFG_MAX_LENGTH:  r_max_length  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Take a word whenever the event queue has room
    assign full   = queue_full;
    assign accept = push && !queue_full;

    ubxp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .i_max_length  (r_max_length),
        .o_event_valid (front_valid),
        .o_event       (front_event)
    );

    ubxp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && front_valid),
        .i_wr_data (front_event),
        .i_rd_en   (back_take),
        .o_rd_data (queue_event),
        .o_full    (queue_full),
        .o_empty   (queue_empty)
    );

    ubxp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_event_valid     (!queue_empty),
        .i_event           (queue_event),
        .o_event_take      (back_take),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_kind            (o_kind),
        .o_payload_byte    (o_payload_byte),
        .o_byte_index      (o_byte_index),
        .o_hdr_class       (o_hdr_class),
        .o_msg_id          (o_msg_id),
        .o_payload_length  (o_payload_length),
        .o_frames_good     (o_frames_good),
        .o_checksum_errors (o_checksum_errors),
        .o_length_errors   (o_length_errors)
    );

    // A good frame taken by the back end bumps the good counter by one
    a_good_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_take && queue_event.kind == KIND_GOOD)
        |=> (o_frames_good == $past(o_frames_good) + 32'd1))
        else $error("good frame counter did not advance");

    // A checksum error taken by the back end bumps its counter by one
    a_sum_err_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_take && queue_event.kind == KIND_SUM_ERR)
        |=> (o_checksum_errors == $past(o_checksum_errors) + 32'd1))
        else $error("checksum error counter did not advance");

    // A payload word always lies inside the declared length
    a_index_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_PAYLOAD) |-> (o_byte_index < o_payload_length))
        else $error("payload index beyond declared length");

endmodule
